@@ rtl/asn1_time_to_epoch_defines.svh @@
// Assertion macros for the time converter. Both expect clk and rst in scope.
`ifndef ASN1_TIME_TO_EPOCH_DEFINES_SVH
`define ASN1_TIME_TO_EPOCH_DEFINES_SVH

// same-cycle implication
`define A2E_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("a2e same-cycle check failed");

// next-cycle implication
`define A2E_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("a2e next-cycle check failed");

`endif

@@ rtl/a2e_pkg.sv @@
package a2e_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;
  localparam logic [1:0] ST_LOCAL  = 2'd3;

  // days from 0000-01-01 to 1970-01-01 plus one (day field is 1-based)
  localparam logic signed [22:0] DAY_BIAS = 23'sd719529;
  localparam logic signed [17:0] DAY_SECS = 18'sd86400;
  localparam logic [13:0]        EPOCH_YEAR = 14'd1970;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_generalized;
    logic       last;
  } a2e_in_t;

  typedef struct packed {
    logic signed [38:0] epoch_seconds;
    logic [1:0]         status;
  } a2e_out_t;

  // parsed fields of one string
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  zone_minutes;
    logic        zone_negative;
    logic [1:0]  status;
  } a2e_rec_t;

  // day count and time of day, zone applied
  typedef struct packed {
    logic signed [22:0] days;
    logic signed [18:0] tod;
    logic               pre_epoch;
    logic [1:0]         status;
  } a2e_days_t;

  // days before the first of month m (m = 1..12), non-leap year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/a2e_parser.sv @@
module a2e_parser (
  input  logic              clk,
  input  logic              rst,
  input  a2e_pkg::a2e_in_t  char_data,
  input  logic              char_valid,
  output logic              char_ready,
  output a2e_pkg::a2e_rec_t rec,
  output logic              rec_valid,
  input  logic              rec_ready
);
  import a2e_pkg::*;

  localparam logic [3:0] PH_YEAR      = 4'd0;
  localparam logic [3:0] PH_MONTH     = 4'd1;
  localparam logic [3:0] PH_DAY       = 4'd2;
  localparam logic [3:0] PH_HOUR      = 4'd3;
  localparam logic [3:0] PH_MINUTE    = 4'd4;
  localparam logic [3:0] PH_AFTER_MIN = 4'd5;
  localparam logic [3:0] PH_SECOND    = 4'd6;
  localparam logic [3:0] PH_FRAC      = 4'd7;
  localparam logic [3:0] PH_ZONE      = 4'd8;
  localparam logic [3:0] PH_ZHOUR     = 4'd9;
  localparam logic [3:0] PH_ZMIN      = 4'd10;
  localparam logic [3:0] PH_DONE      = 4'd11;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  logic [3:0]  phase, phase_next;
  logic [1:0]  digit_count, digit_count_next;
  logic [13:0] acc, acc_next;
  logic [13:0] year, year_next;
  logic [3:0]  month, month_next;
  logic [4:0]  day, day_next;
  logic [4:0]  hour, hour_next;
  logic [5:0]  minute, minute_next;
  logic [5:0]  second, second_next;
  logic [9:0]  zone, zone_next;
  logic        zone_neg, zone_neg_next;
  logic        err, err_next;

  logic        take, gen, is_dig, is_sep, fld_done, fld_ok;
  logic [16:0] acc_sum;
  logic [13:0] acc_new, fld_lo, fld_hi;
  logic [3:0]  zc_phase;
  logic        zc_err, zc_z, zc_sign;
  logic [1:0]  status_c;

  assign char_ready = !rec_valid || rec_ready;
  assign take       = char_valid && char_ready;
  assign gen        = char_data.is_generalized;
  assign is_dig     = (char_data.ch >= CH_0) && (char_data.ch <= CH_9);
  assign is_sep     = (char_data.ch == CH_DOT) || (char_data.ch == CH_COMMA);
  assign acc_sum    = {acc, 3'b000} + 17'({acc, 1'b0}) + 17'(char_data.ch[3:0]);
  assign acc_new    = acc_sum[13:0];
  assign fld_done   = (phase == PH_YEAR && gen) ? (digit_count == 2'd3) : (digit_count != 2'd0);
  assign fld_ok     = (acc_new >= fld_lo) && (acc_new <= fld_hi);

  // zone designator: Z, + or -
  assign zc_z     = char_data.ch == CH_Z;
  assign zc_sign  = (char_data.ch == CH_PLUS) || (char_data.ch == CH_MINUS);
  assign zc_err   = !zc_z && !zc_sign;
  assign zc_phase = zc_z ? PH_DONE : (zc_sign ? PH_ZHOUR : PH_ZONE);

  always_comb begin
    fld_lo = 14'd0;
    fld_hi = 14'd99;
    case (phase)
      PH_YEAR:   fld_hi = gen ? 14'd9999 : 14'd99;
      PH_MONTH: begin
        fld_lo = 14'd1;
        fld_hi = 14'd12;
      end
      PH_DAY: begin
        fld_lo = 14'd1;
        fld_hi = 14'd31;
      end
      PH_HOUR:   fld_hi = 14'd23;
      PH_ZHOUR:  fld_hi = 14'd12;
      PH_MINUTE, PH_SECOND, PH_ZMIN: fld_hi = 14'd59;
      default:   fld_hi = 14'd99;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    digit_count_next = digit_count;
    acc_next         = acc;
    year_next        = year;
    month_next       = month;
    day_next         = day;
    hour_next        = hour;
    minute_next      = minute;
    second_next      = second;
    zone_next        = zone;
    zone_neg_next    = zone_neg;
    err_next         = err;
    if (take && !err) begin
      if (phase inside {PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND,
                        PH_ZHOUR, PH_ZMIN}) begin
        if (!is_dig) begin
          err_next = 1'b1;
        end else if (!fld_done) begin
          acc_next         = acc_new;
          digit_count_next = digit_count + 2'd1;
        end else begin
          acc_next         = '0;
          digit_count_next = '0;
          if (!fld_ok) begin
            err_next = 1'b1;
          end else begin
            case (phase)
              PH_YEAR: begin
                if (gen) begin
                  year_next = acc_new;
                end else if (acc_new < 14'd50) begin
                  year_next = acc_new + 14'd2000;
                end else begin
                  year_next = acc_new + 14'd1900;
                end
                phase_next = PH_MONTH;
              end
              PH_MONTH: begin
                month_next = acc_new[3:0];
                phase_next = PH_DAY;
              end
              PH_DAY: begin
                day_next   = acc_new[4:0];
                phase_next = PH_HOUR;
              end
              PH_HOUR: begin
                hour_next  = acc_new[4:0];
                phase_next = PH_MINUTE;
              end
              PH_MINUTE: begin
                minute_next = acc_new[5:0];
                phase_next  = PH_AFTER_MIN;
              end
              PH_SECOND: begin
                second_next = acc_new[5:0];
                phase_next  = gen ? PH_FRAC : PH_ZONE;
              end
              PH_ZHOUR: begin
                zone_next  = 10'(acc_new[3:0]) * 10'd60;
                phase_next = PH_ZMIN;
              end
              PH_ZMIN: begin
                zone_next  = zone + 10'(acc_new[5:0]);
                phase_next = PH_DONE;
              end
              default: err_next = 1'b1;
            endcase
          end
        end
      end else begin
        case (phase)
          PH_AFTER_MIN: begin
            second_next = '0;
            if (is_dig) begin
              acc_next         = 14'(char_data.ch[3:0]);
              digit_count_next = 2'd1;
              phase_next       = PH_SECOND;
            end else if (gen && is_sep) begin
              phase_next = PH_FRAC;
            end else begin
              phase_next = zc_phase;
              err_next   = zc_err;
            end
          end
          PH_FRAC, PH_ZONE: begin
            if (!(phase == PH_FRAC && (is_sep || is_dig))) begin
              phase_next = zc_phase;
              err_next   = zc_err;
            end
          end
          default: err_next = 1'b1;
        endcase
        if ((phase inside {PH_AFTER_MIN, PH_FRAC, PH_ZONE}) && !is_dig && !is_sep) begin
          if (zc_z) begin
            zone_next     = '0;
            zone_neg_next = 1'b0;
          end else if (zc_sign) begin
            zone_neg_next = char_data.ch == CH_MINUS;
          end
        end
      end
    end
  end

  always_comb begin
    if (err_next) begin
      status_c = ST_FORMAT;
    end else if (phase_next == PH_DONE) begin
      status_c = ST_OK;
    end else if (gen && (phase_next == PH_AFTER_MIN || phase_next == PH_FRAC)) begin
      status_c = ST_LOCAL;
    end else begin
      status_c = ST_FORMAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && char_data.last)) begin
      phase       <= PH_YEAR;
      digit_count <= '0;
      acc         <= '0;
      year        <= '0;
      month       <= '0;
      day         <= '0;
      hour        <= '0;
      minute      <= '0;
      second      <= '0;
      zone        <= '0;
      zone_neg    <= 1'b0;
      err         <= 1'b0;
    end else begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      acc         <= acc_next;
      year        <= year_next;
      month       <= month_next;
      day         <= day_next;
      hour        <= hour_next;
      minute      <= minute_next;
      second      <= second_next;
      zone        <= zone_next;
      zone_neg    <= zone_neg_next;
      err         <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (take && char_data.last) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && char_data.last) begin
      rec.year          <= year_next;
      rec.month         <= month_next;
      rec.day           <= day_next;
      rec.hour          <= hour_next;
      rec.minute        <= minute_next;
      rec.second        <= second_next;
      rec.zone_minutes  <= zone_next;
      rec.zone_negative <= zone_neg_next;
      rec.status        <= status_c;
    end
  end

endmodule

@@ rtl/a2e_days.sv @@
module a2e_days (
  input  logic               clk,
  input  logic               rst,
  input  a2e_pkg::a2e_rec_t  rec,
  input  logic               rec_valid,
  output logic               rec_ready,
  output a2e_pkg::a2e_days_t dy,
  output logic               dy_valid,
  input  logic               dy_ready
);
  import a2e_pkg::*;

  // stage 1: year / 100 by reciprocal, minute of day with zone
  logic              s1_valid, s1_ready, dy_free;
  a2e_rec_t          s1_rec;
  logic [6:0]        s1_q;
  logic signed [12:0] s1_mod;

  logic [26:0]       yq;
  logic [12:0]       mod_base;
  logic signed [12:0] mod_c;

  assign dy_free   = !dy_valid || dy_ready;
  assign s1_ready  = !s1_valid || dy_free;
  assign rec_ready = s1_ready;

  assign yq       = 27'(rec.year) * 27'd5243;
  assign mod_base = 13'(rec.hour) * 13'd60 + 13'(rec.minute);
  assign mod_c    = rec.zone_negative ? $signed(mod_base + 13'(rec.zone_minutes))
                                      : $signed(mod_base - 13'(rec.zone_minutes));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && rec_valid) begin
      s1_rec <= rec;
      s1_q   <= yq[25:19];
      s1_mod <= mod_c;
    end
  end

  // stage 2: Gregorian day count and seconds of day
  logic [13:0]        q100;
  logic               r_nz, leap;
  logic [14:0]        yp3;
  logic [12:0]        leaps;
  logic [21:0]        pos;
  logic signed [22:0] days_c;
  logic signed [18:0] tod_c;

  assign q100  = 14'(s1_q) * 14'd100;
  assign r_nz  = s1_rec.year != q100;
  assign leap  = (s1_rec.year[1:0] == 2'b00) && (r_nz || s1_q[1:0] == 2'b00);
  assign yp3   = 15'(s1_rec.year) + 15'd3;
  assign leaps = 13'(yp3[14:2]) - 13'(s1_q) - 13'(r_nz)
               + 13'(s1_q[6:2]) + 13'(r_nz || s1_q[1:0] != 2'b00);
  assign pos   = 22'(s1_rec.year) * 22'd365 + 22'(leaps) + 22'(cum_days(s1_rec.month))
               + 22'(leap && s1_rec.month > 4'd2) + 22'(s1_rec.day);
  assign days_c = $signed({1'b0, pos}) - DAY_BIAS;
  assign tod_c  = 19'(s1_mod) * 19'sd60 + $signed({13'b0, s1_rec.second});

  always_ff @(posedge clk) begin
    if (rst) begin
      dy_valid <= 1'b0;
    end else if (dy_free) begin
      dy_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dy_free && s1_valid) begin
      dy.days      <= days_c;
      dy.tod       <= tod_c;
      dy.pre_epoch <= s1_rec.year < EPOCH_YEAR;
      dy.status    <= s1_rec.status;
    end
  end

endmodule

@@ rtl/a2e_secs.sv @@
module a2e_secs (
  input  logic               clk,
  input  logic               rst,
  input  a2e_pkg::a2e_days_t dy,
  input  logic               dy_valid,
  output logic               dy_ready,
  output a2e_pkg::a2e_out_t  res_data,
  output logic               res_valid,
  input  logic               res_ready
);
  import a2e_pkg::*;

  logic               s1_valid, s1_ready, res_free;
  logic signed [39:0] s1_prod;
  logic signed [18:0] s1_tod;
  logic               s1_pre;
  logic [1:0]         s1_status;

  logic signed [39:0] prod_c, secs;
  logic               bad_sign;
  logic [1:0]         status_c;

  assign res_free = !res_valid || res_ready;
  assign s1_ready = !s1_valid || res_free;
  assign dy_ready = s1_ready;
  assign prod_c   = 40'(dy.days) * 40'(DAY_SECS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= dy_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && dy_valid) begin
      s1_prod   <= prod_c;
      s1_tod    <= dy.tod;
      s1_pre    <= dy.pre_epoch;
      s1_status <= dy.status;
    end
  end

  // sign must agree with the side of 1970 the year lies on
  assign secs     = s1_prod + 40'(s1_tod);
  assign bad_sign = s1_pre ? !secs[39] : secs[39];
  assign status_c = (s1_status != ST_OK) ? s1_status : (bad_sign ? ST_RANGE : ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && s1_valid) begin
      res_data.status        <= status_c;
      res_data.epoch_seconds <= (status_c == ST_OK) ? secs[38:0] : '0;
    end
  end

endmodule

@@ rtl/asn1_time_to_epoch.sv @@
// Channel | Direction | Payload  | Transfer
// char    | in        | a2e_in_t  | char_valid && char_ready, one character each
// res     | out       | a2e_out_t | res_valid && res_ready, one per string
//
// One character per cycle sustained while char_ready holds; the result of a
// string passes through the record, two day-count and two seconds registers.
// Reset (rst, synchronous) clears the parser state and all valids.
// A stalled res_ready fills the five result registers in turn; char_ready drops
// only while the record register is full and cannot move on.
`include "asn1_time_to_epoch_defines.svh"

module asn1_time_to_epoch (
  input  logic              clk,
  input  logic              rst,
  input  a2e_pkg::a2e_in_t  char_data,
  input  logic              char_valid,
  output logic              char_ready,
  output a2e_pkg::a2e_out_t res_data,
  output logic              res_valid,
  input  logic              res_ready
);
  import a2e_pkg::*;

  a2e_rec_t  rec;
  logic      rec_valid, rec_ready;
  a2e_days_t dy;
  logic      dy_valid, dy_ready;

  a2e_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .char_data  (char_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .rec        (rec),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready)
  );

  a2e_days u_days (
    .clk       (clk),
    .rst       (rst),
    .rec       (rec),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .dy        (dy),
    .dy_valid  (dy_valid),
    .dy_ready  (dy_ready)
  );

  a2e_secs u_secs (
    .clk       (clk),
    .rst       (rst),
    .dy        (dy),
    .dy_valid  (dy_valid),
    .dy_ready  (dy_ready),
    .res_data  (res_data),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  `A2E_ASSERT_IMPL(a_err_zero, res_valid && res_data.status != ST_OK, res_data.epoch_seconds == '0)
  `A2E_ASSERT_IMPL(a_stall_src, !char_ready, rec_valid)
  `A2E_ASSERT_NEXT(a_last_rec, char_valid && char_ready && char_data.last, rec_valid)
  `A2E_ASSERT_IMPL(a_month_ok, rec_valid && rec.status == ST_OK, rec.month >= 4'd1 && rec.month <= 4'd12)

endmodule

@@ dv/asn1_time_checker.sv @@
module asn1_time_checker (
  input  logic              clk,
  input  logic              rst,
  input  a2e_pkg::a2e_in_t  char_data,
  input  logic              char_valid,
  input  logic              char_ready,
  input  a2e_pkg::a2e_out_t res_data,
  input  logic              res_valid,
  input  logic              res_ready,
  output int                fail_count,
  output int                open_count,
  output int                checked_count,
  output int                ok_count
);
  import a2e_pkg::*;

  typedef enum logic [4:0] {
    P_YEAR, P_MONTH, P_DAY, P_HOUR, P_MINUTE, P_AFTER_MIN, P_SECOND,
    P_FRAC, P_ZONE, P_ZHOUR, P_ZMIN, P_DONE
  } parse_phase_e;

  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;
  localparam logic [7:0] UTC_CHAR   = 8'h5A;
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;
  localparam logic [7:0] COMMA_CHAR = 8'h2C;
  localparam int         UNIX_YEAR  = 1970;

  parse_phase_e ph;
  logic [2:0]   ndig;
  logic [13:0]  acc;
  logic [13:0]  yr;
  logic [3:0]   mon;
  logic [4:0]   dom;
  logic [4:0]   hr;
  logic [5:0]   mnt;
  logic [5:0]   sec;
  logic [10:0]  zmin;
  logic         zneg;
  logic [1:0]   err;

  a2e_out_t expected_times[$];
  int       errs;
  int       checked;
  int       oks;

  function automatic void clear_parser();
    ph   = P_YEAR;
    ndig = '0;
    acc  = '0;
    yr   = '0;
    mon  = '0;
    dom  = '0;
    hr   = '0;
    mnt  = '0;
    sec  = '0;
    zmin = '0;
    zneg = 1'b0;
    err  = ST_OK;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= ZERO_CHAR && c <= NINE_CHAR;
  endfunction

  // accumulate one digit; true once the field is complete and within [lo, hi]
  function automatic bit take_field(input logic [7:0] c, input int n, input int lo,
                                    input int hi, output int v);
    v = 0;
    if (!is_num(c)) begin
      err = ST_FORMAT;
      return 1'b0;
    end
    acc  = 14'(acc * 10 + (c - ZERO_CHAR));
    ndig = ndig + 3'd1;
    if (ndig < n) return 1'b0;
    v    = int'(acc);
    acc  = '0;
    ndig = '0;
    if (v < lo || v > hi) begin
      err = ST_FORMAT;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void take_zone(input logic [7:0] c);
    if (c == UTC_CHAR) begin
      zmin = '0;
      zneg = 1'b0;
      ph   = P_DONE;
    end else if (c == PLUS_CHAR || c == MINUS_CHAR) begin
      zneg = (c == MINUS_CHAR);
      ph   = P_ZHOUR;
    end else begin
      err = ST_FORMAT;
    end
  endfunction

  function automatic void advance_parser(input logic [7:0] c, input logic gen);
    int v;
    v = 0;
    case (ph)
      P_YEAR: begin
        if (gen) begin
          if (take_field(c, 4, 0, 9999, v)) begin
            yr = 14'(v);
            ph = P_MONTH;
          end
        end else if (take_field(c, 2, 0, 99, v)) begin
          yr = 14'(v < 50 ? v + 2000 : v + 1900);
          ph = P_MONTH;
        end
      end
      P_MONTH: begin
        if (take_field(c, 2, 1, 12, v)) begin
          mon = 4'(v);
          ph  = P_DAY;
        end
      end
      P_DAY: begin
        if (take_field(c, 2, 1, 31, v)) begin
          dom = 5'(v);
          ph  = P_HOUR;
        end
      end
      P_HOUR: begin
        if (take_field(c, 2, 0, 23, v)) begin
          hr = 5'(v);
          ph = P_MINUTE;
        end
      end
      P_MINUTE: begin
        if (take_field(c, 2, 0, 59, v)) begin
          mnt = 6'(v);
          ph  = P_AFTER_MIN;
        end
      end
      P_AFTER_MIN: begin
        sec = '0;
        if (is_num(c)) begin
          acc  = 14'(c - ZERO_CHAR);
          ndig = 3'd1;
          ph   = P_SECOND;
        end else if (gen && (c == DOT_CHAR || c == COMMA_CHAR)) begin
          ph = P_FRAC;
        end else begin
          ph = P_ZONE;
          take_zone(c);
        end
      end
      P_SECOND: begin
        if (take_field(c, 2, 0, 59, v)) begin
          sec = 6'(v);
          ph  = gen ? P_FRAC : P_ZONE;
        end
      end
      P_FRAC: begin
        if (!(c == DOT_CHAR || c == COMMA_CHAR || is_num(c))) begin
          ph = P_ZONE;
          take_zone(c);
        end
      end
      P_ZONE: begin
        take_zone(c);
      end
      P_ZHOUR: begin
        if (take_field(c, 2, 0, 12, v)) begin
          zmin = 11'(v * 60);
          ph   = P_ZMIN;
        end
      end
      P_ZMIN: begin
        if (take_field(c, 2, 0, 59, v)) begin
          zmin = 11'(zmin + v);
          ph   = P_DONE;
        end
      end
      default: begin
        err = ST_FORMAT;
      end
    endcase
  endfunction

  // leap years in [0, y-1], year 0 included
  function automatic longint leap_days_before(input longint y);
    return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint seconds_since_epoch();
    longint y;
    longint days;
    longint zone;
    longint secs;
    bit     leap;
    y    = longint'(yr);
    leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    days = 365 * (y - UNIX_YEAR) + leap_days_before(y) - leap_days_before(UNIX_YEAR);
    if (mon >= 1 && mon <= 12) begin
      for (int m = 1; m < mon; m++) days += (m == 2) ? 28 : 30 + ((m + m / 8) % 2);
      if (leap && mon > 2) days += 1;
    end
    days += longint'(dom) - 1;
    zone = zneg ? -longint'(zmin) : longint'(zmin);
    secs = days * 86400 + longint'(hr) * 3600 + (longint'(mnt) - zone) * 60
         + longint'(sec);
    if (y < UNIX_YEAR) begin
      if (secs >= 0) err = ST_RANGE;
    end else if (secs < 0) begin
      err = ST_RANGE;
    end
    return secs;
  endfunction

  function automatic void parse_char(input a2e_in_t it, output bit has_time,
                                     output a2e_out_t want);
    longint     secs;
    logic [1:0] st;
    has_time = 1'b0;
    want     = '0;
    secs     = 0;
    if (err == ST_OK) advance_parser(it.ch, it.is_generalized);
    if (!it.last) return;
    if (err != ST_OK) begin
      st = ST_FORMAT;
    end else if (ph == P_DONE) begin
      secs = seconds_since_epoch();
      st   = err;
    end else if (it.is_generalized && (ph == P_AFTER_MIN || ph == P_FRAC)) begin
      st = ST_LOCAL;
    end else begin
      st = ST_FORMAT;
    end
    if (st != ST_OK) secs = 0;
    want.epoch_seconds = secs[38:0];
    want.status        = st;
    has_time           = 1'b1;
    clear_parser();
  endfunction

  always @(posedge clk) begin
    a2e_out_t want;
    bit       has_time;
    if (rst) begin
      clear_parser();
      expected_times.delete();
      errs    = 0;
      checked = 0;
      oks     = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (expected_times.size() == 0) begin
          errs++;
          $display("%0t unexpected result transfer: expected none, got epoch %0d status %0d",
                   $time, res_data.epoch_seconds, res_data.status);
        end else begin
          want = expected_times.pop_front();
          checked++;
          if (want.status == ST_OK) oks++;
          if (res_data.epoch_seconds !== want.epoch_seconds) begin
            errs++;
            $display("%0t epoch_seconds mismatch: expected %0d, got %0d",
                     $time, want.epoch_seconds, res_data.epoch_seconds);
          end
          if (res_data.status !== want.status) begin
            errs++;
            $display("%0t status mismatch: expected %0d, got %0d",
                     $time, want.status, res_data.status);
          end
        end
      end
      if (char_valid && char_ready) begin
        parse_char(char_data, has_time, want);
        if (has_time) expected_times.push_back(want);
      end
    end
    fail_count    <= errs;
    open_count    <= expected_times.size();
    checked_count <= checked;
    ok_count      <= oks;
  end

endmodule

@@ dv/asn1_time_to_epoch_tb.sv @@
module asn1_time_to_epoch_tb;
  import a2e_pkg::*;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_e;

  localparam int         RANDOM_CHARS = 1350;
  localparam int         RX_HOLD      = 400;
  localparam int         STALL_LIMIT  = 5000;
  localparam logic [7:0] ZERO_CHAR    = "0";

  logic     clk;
  logic     rst;
  a2e_in_t  char_data;
  logic     char_valid;
  logic     char_ready;
  a2e_out_t res_data;
  logic     res_valid;
  logic     res_ready;

  int fail_count;
  int open_count;
  int checked_count;
  int ok_count;

  a2e_in_t line_q[$];
  logic    line_gen;
  logic    hold_req;
  int      burst_left   = 0;
  int      sent_chars   = 0;
  int      strings_sent = 0;
  int      hold_mark    = -1;
  int      quiet_cycles = 0;

  asn1_time_to_epoch dut (
    .clk        (clk),
    .rst        (rst),
    .char_data  (char_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .res_data   (res_data),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  asn1_time_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .char_data     (char_data),
    .char_valid    (char_valid),
    .char_ready    (char_ready),
    .res_data      (res_data),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count),
    .ok_count      (ok_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic void add_char(input logic [7:0] c);
    a2e_in_t it;
    it.ch             = c;
    it.is_generalized = line_gen;
    it.last           = 1'b0;
    line_q.push_back(it);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  function automatic void add_digits(input int v, input int n);
    int p;
    p = 1;
    repeat (n - 1) p *= 10;
    while (p > 0) begin
      add_char(ZERO_CHAR + 8'((v / p) % 10));
      p /= 10;
    end
  endfunction

  // damage a well-formed string in one of several ways
  function automatic void mangle_line();
    int    pos;
    string junk;
    junk = "Z+-0.";
    pos  = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 4))
      0: line_q[pos].ch = 8'($urandom_range(0, 255));
      1: line_q[pos].ch = ZERO_CHAR + 8'($urandom_range(0, 9));
      2: while (line_q.size() > pos + 1) line_q.delete(line_q.size() - 1);
      3: repeat ($urandom_range(1, 3)) add_char(junk[$urandom_range(0, 4)]);
      default: line_q[pos].is_generalized = ~line_q[pos].is_generalized;
    endcase
  endfunction

  function automatic void build_random_line();
    int kind;
    int yr;
    int mo;
    int dy;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 20)) begin
        line_gen = 1'($urandom_range(0, 1));
        add_char(8'($urandom_range(0, 255)));
      end
      return;
    end
    line_gen = 1'($urandom_range(0, 1));
    mo = $urandom_range(1, 12);
    dy = $urandom_range(1, 31);
    case ($urandom_range(0, 4))
      0: yr = $urandom_range(0, 9999);
      1: yr = $urandom_range(1900, 2100);
      2: begin
        // right around the epoch, where the zone can flip the sign
        yr = $urandom_range(0, 1) ? 1969 : 1970;
        mo = (yr == 1969) ? 12 : 1;
        dy = (yr == 1969) ? 31 : 1;
      end
      3: yr = $urandom_range(0, 1) ? 0 : 9999;
      default: yr = $urandom_range(1950, 2049);
    endcase
    if (line_gen) add_digits(yr, 4);
    else add_digits(yr % 100, 2);
    add_digits(mo, 2);
    add_digits(dy, 2);
    add_digits($urandom_range(0, 23), 2);
    add_digits($urandom_range(0, 59), 2);
    if ($urandom_range(0, 6) != 0) add_digits($urandom_range(0, 59), 2);
    if (line_gen && $urandom_range(0, 3) == 0) begin
      add_char($urandom_range(0, 1) ? "." : ",");
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 4) == 0) add_char($urandom_range(0, 1) ? "." : ",");
        else add_char(ZERO_CHAR + 8'($urandom_range(0, 9)));
      end
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_char("Z");
      9: ;
      default: begin
        add_char($urandom_range(0, 1) ? "-" : "+");
        add_digits($urandom_range(0, 12), 2);
        add_digits($urandom_range(0, 59), 2);
      end
    endcase
    if (kind >= 78) mangle_line();
  endfunction

  task automatic send_line();
    line_q[line_q.size() - 1].last = 1'b1;
    foreach (line_q[i]) begin
      if (burst_left == 0) begin
        char_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 25);
      end
      char_data  <= line_q[i];
      char_valid <= 1'b1;
      @(posedge clk);
      while (!char_ready) @(posedge clk);
      burst_left--;
      sent_chars++;
      if (sent_chars == hold_mark) hold_req <= 1'b1;
    end
    strings_sent++;
    line_q.delete();
  endtask

  task automatic send_text(input logic gen, input string s);
    line_gen = gen;
    add_text(s);
    send_line();
  endtask

  initial begin : stimulus
    int target;
    char_valid <= 1'b0;
    char_data  <= '0;
    hold_req   <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);

    send_text(1'b0, "700101000000Z");
    send_text(1'b1, "19700101000000Z");
    send_text(1'b1, "00000101000000+1259");
    send_text(1'b1, "99991231235959-1200");
    send_text(1'b0, "491231235959Z");
    send_text(1'b0, "500101000000+0530");
    send_text(1'b1, "20000229120000Z");
    send_text(1'b1, "21000301000000-0000");
    send_text(1'b1, "20240615103000.123Z");
    send_text(1'b1, "202406151030,5+0100");
    send_text(1'b1, "202406151030Z");
    send_text(1'b0, "2406151030-0800");
    send_text(1'b1, "20240615103000");
    send_text(1'b1, "202406151030");
    send_text(1'b1, "20240615103000.25");
    send_text(1'b0, "2406151030");
    send_text(1'b1, "19691231235959-1200");
    send_text(1'b1, "19700101000000+0100");
    send_text(1'b1, "20241301000000Z");
    send_text(1'b1, "20240100000000Z");
    send_text(1'b1, "20240101240000Z");
    send_text(1'b1, "20240615103000+1300");
    send_text(1'b1, "20240615103000+1260");
    send_text(1'b1, "20240615103000ZX");
    send_text(1'b1, "20240615103000Q");
    send_text(1'b1, "20240615103000+12");
    send_text(1'b0, "2406151030.Z");
    send_text(1'b1, "2024");
    line_gen = 1'b1;
    add_text("2024");
    add_char(8'h00);
    add_text("0615103000Z");
    send_line();

    // drain everything before the random part
    char_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);

    hold_mark = sent_chars + 300;
    target    = sent_chars + RANDOM_CHARS;
    while (sent_chars < target) begin
      build_random_line();
      send_line();
    end

    char_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    $display("Sent %0d characters in %0d strings; %0d results compared, %0d valid times.",
             sent_chars, strings_sent, checked_count, ok_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : receiver
    rx_mode_e rx_mode;
    int       span;
    int       tick;
    bit       hold_done;
    rx_mode   = RX_FREE;
    span      = 0;
    tick      = 0;
    hold_done = 1'b0;
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        res_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      if (span == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        span    = $urandom_range(16, 160);
      end
      span--;
      tick++;
      case (rx_mode)
        RX_FREE:   res_ready <= 1'b1;
        RX_RANDOM: res_ready <= ($urandom_range(0, 2) != 0);
        default:   res_ready <= (tick % 7 < 2);
      endcase
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (res_valid && res_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t timeout: no transfer for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
